>>> rtl/core/cprd_pkg.sv
// ----------------------------------------------------------------------------
// cprd_pkg
// shared constants, types and small functions for the run-length pattern
// decoder
// ----------------------------------------------------------------------------
`default_nettype none

package cprd_pkg;

   // grid limits
   localparam int MAX_DIM   = 1024;
   localparam int DIM_W     = $clog2(MAX_DIM + 1);
   localparam int POS_W     = 10;
   localparam int SYM_W     = 8;
   localparam int LEVEL_W   = 8;
   localparam int PREFIX_W  = 4;
   localparam int LETTER_W  = 5;
   localparam int DIGIT_W   = 4;
   localparam int PROD_W    = DIM_W + 4;

   // csr
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [DIM_W-1:0] GRID_WIDTH_RESET  = DIM_W'(64);
   localparam logic [DIM_W-1:0] GRID_HEIGHT_RESET = DIM_W'(64);

   typedef enum logic [0:0] {
      REG_GRID_WIDTH  = 1'b0,
      REG_GRID_HEIGHT = 1'b1
   } reg_index_type;

   // character codes
   localparam logic [SYM_W-1:0] CH_BANG   = 8'h21;
   localparam logic [SYM_W-1:0] CH_DOLLAR = 8'h24;
   localparam logic [SYM_W-1:0] CH_DOT    = 8'h2E;
   localparam logic [SYM_W-1:0] CH_ZERO   = 8'h30;
   localparam logic [SYM_W-1:0] CH_NINE   = 8'h39;
   localparam logic [SYM_W-1:0] CH_UPPER_A = 8'h41;
   localparam logic [SYM_W-1:0] CH_UPPER_X = 8'h58;
   localparam logic [SYM_W-1:0] CH_LOWER_B = 8'h62;
   localparam logic [SYM_W-1:0] CH_LOWER_O = 8'h6F;
   localparam logic [SYM_W-1:0] CH_LOWER_P = 8'h70;
   localparam logic [SYM_W-1:0] CH_LOWER_Y = 8'h79;

   // levels
   localparam logic [LEVEL_W-1:0] LEVEL_FULL  = 8'd255;
   localparam logic [LEVEL_W-1:0] LEVEL_BLANK = 8'd0;
   localparam int LEVEL_SPAN  = 24;
   localparam int PREFIX_BASE = 25;
   localparam int DEC_RADIX   = 10;

   // decoded character
   typedef struct packed {
      logic                is_digit;
      logic [DIGIT_W-1:0]  digit;
      logic                is_letter;
      logic [LETTER_W-1:0] letter;
      logic                is_prefix;
      logic [PREFIX_W-1:0] prefix;
      logic                is_full;
      logic                is_blank;
      logic                is_row;
      logic                is_end;
   } sym_class_type;

   // one result item
   typedef struct packed {
      logic [POS_W-1:0]   row;
      logic [POS_W-1:0]   col;
      logic [DIM_W-1:0]   length;
      logic [LEVEL_W-1:0] level;
      logic               pattern_end;
      logic               clipped;
   } run_type;

   // register value used as 1..MAX_DIM
   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
      logic [DIM_W-1:0] r;
      if (v == '0) begin
         r = DIM_W'(1);
      end else if (v > DIM_W'(MAX_DIM)) begin
         r = DIM_W'(MAX_DIM);
      end else begin
         r = v;
      end
      return r;
   endfunction

   // two-letter level, saturating at full
   function automatic logic [LEVEL_W-1:0] prefix_level(input logic [PREFIX_W-1:0] p,
                                                       input logic [LETTER_W-1:0] l);
      logic [LEVEL_W:0] sum;
      sum = 9'((9'(p) - 9'd1) * 9'(LEVEL_SPAN)) + 9'(l) + 9'(PREFIX_BASE);
      if (sum > 9'(LEVEL_FULL)) begin
         return LEVEL_FULL;
      end
      return sum[LEVEL_W-1:0];
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/cprd_decode.sv
// ----------------------------------------------------------------------------
// cprd_decode
// sorts one pattern character into its class and value
// ----------------------------------------------------------------------------
`default_nettype none

module cprd_decode (
   input  wire logic [cprd_pkg::SYM_W-1:0] symbol,
   output cprd_pkg::sym_class_type         cls
);
   import cprd_pkg::*;

   logic [SYM_W-1:0] from_zero;
   logic [SYM_W-1:0] from_a;
   logic [SYM_W-1:0] from_p;

   assign from_zero = symbol - CH_ZERO;
   assign from_a    = symbol - CH_UPPER_A;
   assign from_p    = symbol - CH_LOWER_P;

   always_comb begin
      cls           = '0;
      cls.is_digit  = (symbol >= CH_ZERO) && (symbol <= CH_NINE);
      cls.digit     = from_zero[DIGIT_W-1:0];
      cls.is_letter = (symbol >= CH_UPPER_A) && (symbol <= CH_UPPER_X);
      cls.letter    = from_a[LETTER_W-1:0];
      cls.is_prefix = (symbol >= CH_LOWER_P) && (symbol <= CH_LOWER_Y);
      // 'p' is prefix 1, zero means none
      cls.prefix    = from_p[PREFIX_W-1:0] + PREFIX_W'(1);
      cls.is_full   = (symbol == CH_LOWER_O);
      cls.is_blank  = (symbol == CH_LOWER_B) || (symbol == CH_DOT);
      cls.is_row    = (symbol == CH_DOLLAR);
      cls.is_end    = (symbol == CH_BANG);
   end

endmodule

`default_nettype wire

>>> rtl/core/cprd_step.sv
// ----------------------------------------------------------------------------
// cprd_step
// decoder state (count, prefix, position, end flag) and the run builder
// ----------------------------------------------------------------------------
`default_nettype none

module cprd_step (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       advance,
   input  wire cprd_pkg::sym_class_type    cls,
   input  wire logic [cprd_pkg::DIM_W-1:0] width,
   input  wire logic [cprd_pkg::DIM_W-1:0] height,
   output logic                            emit,
   output cprd_pkg::run_type               run
);
   import cprd_pkg::*;

   logic [DIM_W-1:0]    count_ff,  count_in;
   logic [PREFIX_W-1:0] prefix_ff, prefix_in;
   logic [DIM_W-1:0]    row_ff,    row_in;
   logic [DIM_W-1:0]    col_ff,    col_in;
   logic                finished_ff, finished_in;

   logic [DIM_W-1:0]   n;
   logic [DIM_W-1:0]   room;
   logic [DIM_W-1:0]   len;
   logic               fits;
   logic               cut;
   logic               off_rows;
   logic [DIM_W-1:0]   row_c;
   logic [DIM_W-1:0]   col_c;
   logic [LEVEL_W-1:0] level;
   logic               is_cell;
   logic [PROD_W-1:0]  count_next;
   logic [DIM_W:0]     row_sum;

   assign n        = (count_ff == '0) ? DIM_W'(1) : count_ff;
   assign room     = (col_ff < width) ? (width - col_ff) : '0;
   assign fits     = n < room;
   assign cut      = n > room;
   assign len      = fits ? n : room;
   assign off_rows = row_ff >= height;
   assign row_c    = off_rows ? (height - DIM_W'(1)) : row_ff;
   assign col_c    = (col_ff < width) ? col_ff : (width - DIM_W'(1));
   assign is_cell  = cls.is_letter || cls.is_full || cls.is_blank;
   assign emit     = !finished_ff && (is_cell || cls.is_end);

   assign count_next = PROD_W'(count_ff) * PROD_W'(DEC_RADIX) + PROD_W'(cls.digit);
   assign row_sum    = (DIM_W+1)'(row_ff) + (DIM_W+1)'(n);

   always_comb begin
      priority if (cls.is_letter) begin
         level = (prefix_ff != '0) ? prefix_level(prefix_ff, cls.letter)
                                   : LEVEL_W'(cls.letter) + LEVEL_W'(1);
      end else if (cls.is_full) begin
         level = LEVEL_FULL;
      end else begin
         level = LEVEL_BLANK;
      end
   end

   always_comb begin
      run.row = row_c[POS_W-1:0];
      run.col = col_c[POS_W-1:0];
      if (cls.is_end) begin
         run.length      = '0;
         run.level       = LEVEL_BLANK;
         run.pattern_end = 1'b1;
         run.clipped     = 1'b0;
      end else begin
         run.length      = off_rows ? '0 : len;
         run.level       = level;
         run.pattern_end = 1'b0;
         run.clipped     = off_rows || cut;
      end
   end

   always_comb begin
      count_in    = count_ff;
      prefix_in   = prefix_ff;
      row_in      = row_ff;
      col_in      = col_ff;
      finished_in = finished_ff;
      if (advance && !finished_ff) begin
         priority if (cls.is_digit) begin
            count_in  = (count_next > PROD_W'(MAX_DIM)) ? DIM_W'(MAX_DIM)
                                                        : count_next[DIM_W-1:0];
            prefix_in = '0;
         end else if (is_cell) begin
            col_in    = fits ? (col_ff + n) : width;
            count_in  = '0;
            prefix_in = '0;
         end else if (cls.is_prefix) begin
            prefix_in = cls.prefix;
         end else if (cls.is_row) begin
            row_in    = (row_sum > (DIM_W+1)'(height)) ? height : row_sum[DIM_W-1:0];
            col_in    = '0;
            count_in  = '0;
            prefix_in = '0;
         end else if (cls.is_end) begin
            count_in    = '0;
            prefix_in   = '0;
            finished_in = 1'b1;
         end else begin
            // anything else leaves the state alone
            count_in = count_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         prefix_ff   <= '0;
         row_ff      <= '0;
         col_ff      <= '0;
         finished_ff <= 1'b0;
      end else begin
         count_ff    <= count_in;
         prefix_ff   <= prefix_in;
         row_ff      <= row_in;
         col_ff      <= col_in;
         finished_ff <= finished_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/cell_pattern_rle_decoder.sv
// ----------------------------------------------------------------------------
// cell_pattern_rle_decoder
// multistate run-length pattern decoder, one character per item in, one run
// item out per cell symbol and one end item for the terminating character
// ----------------------------------------------------------------------------
//
//   channel   direction  ports    payload
//   req       in         valid/ready  symbol (8b ascii)
//   rsp       out        valid/ready  run_row, run_col, run_length,
//                                     cell_level, pattern_end, clipped
//   csr       in/out     apb-style    grid_width @0x0, grid_height @0x4
//
// one item per cycle sustained while no stall holds it: an item waits in
// the input register, is decoded and applied to the state on its way out,
// and its run or end item (if any) lands in the result register that drives rsp_valid
// the only stall is a cell or end item meeting a full result register that
// is not being taken that cycle; digits, prefixes, row moves and ignored
// characters pass through the input register even then
// synchronous active-high reset clears the position, count, prefix and end
// flag and sets both grid registers to 64; no clearing pass
//
`default_nettype none

module cell_pattern_rle_decoder (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // input channel
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic [cprd_pkg::SYM_W-1:0]      req_symbol,
   // result channel
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic [cprd_pkg::POS_W-1:0]           rsp_run_row,
   output logic [cprd_pkg::POS_W-1:0]           rsp_run_col,
   output logic [cprd_pkg::DIM_W-1:0]           rsp_run_length,
   output logic [cprd_pkg::LEVEL_W-1:0]         rsp_cell_level,
   output logic                                 rsp_pattern_end,
   output logic                                 rsp_clipped,
   // configuration
   input  wire logic                            csr_psel,
   input  wire logic                            csr_penable,
   input  wire logic                            csr_pwrite,
   input  wire logic [cprd_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [cprd_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [cprd_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                 csr_pready
);
   import cprd_pkg::*;

   // grid registers
   logic [DIM_W-1:0] grid_width_ff,  grid_width_in;
   logic [DIM_W-1:0] grid_height_ff, grid_height_in;
   logic [DIM_W-1:0] width_c;
   logic [DIM_W-1:0] height_c;
   reg_index_type    csr_index;
   logic             csr_write;

   // input register
   logic             in_valid_ff, in_valid_in;
   logic [SYM_W-1:0] in_symbol_ff, in_symbol_in;

   // result register
   logic             out_valid_ff, out_valid_in;
   run_type          out_run_ff, out_run_in;

   sym_class_type    cls;
   logic             emit;
   logic             advance;
   run_type          run;

   // ---------------------------------------------------------------- csr
   assign csr_pready = 1'b1;
   assign csr_index  = reg_index_type'(csr_paddr[2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      grid_width_in  = grid_width_ff;
      grid_height_in = grid_height_ff;
      if (csr_write) begin
         unique case (csr_index)
            REG_GRID_WIDTH:  grid_width_in  = csr_pwdata[DIM_W-1:0];
            REG_GRID_HEIGHT: grid_height_in = csr_pwdata[DIM_W-1:0];
            default:         grid_width_in  = grid_width_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_GRID_WIDTH:  csr_prdata = CSR_DATA_W'(grid_width_ff);
         REG_GRID_HEIGHT: csr_prdata = CSR_DATA_W'(grid_height_ff);
         default:         csr_prdata = '0;
      endcase
   end

   // registers are used as 1..MAX_DIM
   assign width_c  = clamp_dim(grid_width_ff);
   assign height_c = clamp_dim(grid_height_ff);

   // ---------------------------------------------------------------- datapath
   cprd_decode u_decode (
      .symbol (in_symbol_ff),
      .cls    (cls)
   );

   cprd_step u_step (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .cls     (cls),
      .width   (width_c),
      .height  (height_c),
      .emit    (emit),
      .run     (run)
   );

   // an item leaves the input register unless it makes a run or end item and the result
   // register stays occupied
   assign advance   = in_valid_ff && (!emit || !out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_symbol_in = in_symbol_ff;
      if (req_ready) begin
         in_valid_in  = req_valid;
         in_symbol_in = req_symbol;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_run_in   = out_run_ff;
      if (advance && emit) begin
         out_valid_in = 1'b1;
         out_run_in   = run;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff  <= GRID_WIDTH_RESET;
         grid_height_ff <= GRID_HEIGHT_RESET;
         in_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         grid_width_ff  <= grid_width_in;
         grid_height_ff <= grid_height_in;
         in_valid_ff    <= in_valid_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      in_symbol_ff <= in_symbol_in;
      out_run_ff   <= out_run_in;
   end

   // ---------------------------------------------------------------- outputs
   assign rsp_valid       = out_valid_ff;
   assign rsp_run_row     = out_run_ff.row;
   assign rsp_run_col     = out_run_ff.col;
   assign rsp_run_length  = out_run_ff.length;
   assign rsp_cell_level  = out_run_ff.level;
   assign rsp_pattern_end = out_run_ff.pattern_end;
   assign rsp_clipped     = out_run_ff.clipped;

endmodule

`default_nettype wire

>>> rtl/core/cprd_checker.sv
// ----------------------------------------------------------------------------
// cprd_checker
// port-level checks on the result channel of the pattern decoder
// ----------------------------------------------------------------------------
`default_nettype none

module cprd_checker (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             rsp_valid,
   input wire logic                             rsp_ready,
   input wire logic [cprd_pkg::POS_W-1:0]       rsp_run_row,
   input wire logic [cprd_pkg::POS_W-1:0]       rsp_run_col,
   input wire logic [cprd_pkg::DIM_W-1:0]       rsp_run_length,
   input wire logic [cprd_pkg::LEVEL_W-1:0]     rsp_cell_level,
   input wire logic                             rsp_pattern_end,
   input wire logic                             rsp_clipped
);
   import cprd_pkg::*;

   logic [DIM_W:0] run_span;

   assign run_span = (DIM_W+1)'(rsp_run_col) + (DIM_W+1)'(rsp_run_length);

   // no result straight out of reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_run_row)
         && $stable(rsp_run_col) && $stable(rsp_run_length)
         && $stable(rsp_cell_level) && $stable(rsp_pattern_end)
         && $stable(rsp_clipped))
      else $error("stalled result changed");

   // end marker carries no cells
   a_end_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_pattern_end |->
         rsp_run_length == '0 && !rsp_clipped && rsp_cell_level == '0)
      else $error("end marker with cells, level or clip");

   // an unclipped run places at least one cell
   a_unclipped_nonempty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_pattern_end && !rsp_clipped |-> rsp_run_length != '0)
      else $error("unclipped run of zero length");

   // a placed run stays inside the largest grid
   a_run_in_grid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_run_length != '0 |-> run_span <= (DIM_W+1)'(MAX_DIM))
      else $error("run passes the grid edge");

endmodule

bind cell_pattern_rle_decoder cprd_checker u_cprd_checker (.*);

`default_nettype wire
